>>> rtl/dqmm_pkg.sv
package dqmm_pkg;

  localparam int unsigned DefaultDepth = 64;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_QUERY      = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] max_value;
    logic signed [31:0] min_value;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic exec;
    logic start_scan;
    logic issue_rd;
    logic load_result;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic scan_req;
    logic last_issue;
  } sts_t;

endpackage

>>> rtl/double_ended_queue_min_max_unit.sv
// Bounded double-ended queue of signed 32-bit values in a DEPTH-entry ring store, with
// push/pop at either end and a max/min query. Every accepted item returns exactly one
// result item through an output register; a new item is taken only once that register
// is free, which includes the cycle in which the previous result leaves. Pushes, pops,
// queries on an empty queue and unused opcodes are executed in the cycle of acceptance
// and may follow back to back. A query on a non-empty queue walks the held entries,
// read one per cycle through the single registered read port of the store; the running
// max and min follow each read in the cycle after it, and the result is then loaded once
// the output register is free; the input stays stalled meanwhile. No clearing pass runs
// after reset: only written entries are ever read.
module double_ended_queue_min_max_unit #(
  parameter int unsigned DEPTH = dqmm_pkg::DefaultDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // item in
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dqmm_pkg::in_item_t  in_item_i,
  // item out
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dqmm_pkg::out_item_t out_item_o
);

  dqmm_pkg::cmd_t cmd;
  dqmm_pkg::sts_t sts;

  // sequencing: idle, address walk, read drain, result load
  dqmm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // ring store, pointers, count, max/min accumulators and output register
  dqmm_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .out_item_o  (out_item_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  // at most one command per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.exec, cmd.start_scan, cmd.issue_rd, cmd.load_result}))
    else $error("more than one datapath command at once");

  // a result is never written over one that has not been taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.exec || cmd.load_result) |-> (!out_valid_o || out_ready_i))
    else $error("output register overwritten");

  // once a scan starts, no item is taken in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start_scan |=> !in_ready_o)
    else $error("item accepted during a scan");

  // an item is accepted only together with a command for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> (cmd.exec || cmd.start_scan))
    else $error("item accepted without a command");

endmodule

>>> rtl/dqmm_ctrl.sv
module dqmm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  dqmm_pkg::sts_t sts_i,
  output dqmm_pkg::cmd_t cmd_o
);

  dqmm_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dqmm_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      dqmm_pkg::S_IDLE: begin
        in_ready_o = sts_i.out_free;
        if (in_valid_i && sts_i.out_free) begin
          if (sts_i.scan_req) begin
            cmd_o.start_scan = 1'b1;
            state_d          = dqmm_pkg::S_SCAN;
          end else begin
            cmd_o.exec = 1'b1;
          end
        end
      end
      dqmm_pkg::S_SCAN: begin
        cmd_o.issue_rd = 1'b1;
        if (sts_i.last_issue) begin
          state_d = dqmm_pkg::S_DRAIN;
        end
      end
      dqmm_pkg::S_DRAIN: begin
        // last read word is folded in at the end of this cycle
        state_d = dqmm_pkg::S_RESULT;
      end
      dqmm_pkg::S_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.load_result = 1'b1;
          state_d           = dqmm_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = dqmm_pkg::S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/dqmm_dpath.sv
module dqmm_dpath #(
  parameter int unsigned DEPTH = dqmm_pkg::DefaultDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dqmm_pkg::in_item_t  in_item_i,
  output dqmm_pkg::out_item_t out_item_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  dqmm_pkg::cmd_t      cmd_i,
  output dqmm_pkg::sts_t      sts_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [31:0] mem [DEPTH];

  logic [AW-1:0] front_q, front_d;
  logic [AW-1:0] back_q, back_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] scan_ptr_q;
  logic [CW-1:0] remaining_q;
  logic          rd_vld_q;
  logic          first_q;
  logic [31:0]   rd_data_q;
  logic signed [31:0] hi_q, lo_q;
  logic          out_valid_q;
  dqmm_pkg::out_item_t out_item_q;
  dqmm_pkg::out_item_t exec_res;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          empty, full;
  logic [AW-1:0] front_prev, front_next, back_prev, back_next, scan_next;

  assign empty = (count_q == '0);
  assign full  = (count_q == CW'(DEPTH));

  assign front_prev = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
  assign front_next = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);
  assign back_prev  = (back_q == '0) ? AW'(DEPTH - 1) : back_q - AW'(1);
  assign back_next  = (back_q == AW'(DEPTH - 1)) ? '0 : back_q + AW'(1);
  assign scan_next  = (scan_ptr_q == AW'(DEPTH - 1)) ? '0 : scan_ptr_q + AW'(1);

  // operations executed directly on acceptance, without a scan
  always_comb begin
    front_d   = front_q;
    back_d    = back_q;
    count_d   = count_q;
    mem_we    = 1'b0;
    mem_waddr = back_q;
    exec_res  = '0;
    exec_res.status = dqmm_pkg::ST_DONE;
    if (cmd_i.exec) begin
      case (in_item_i.opcode)
        dqmm_pkg::OP_PUSH_FRONT: begin
          if (full) begin
            exec_res.status = dqmm_pkg::ST_FULL;
          end else begin
            front_d   = front_prev;
            mem_we    = 1'b1;
            mem_waddr = front_prev;
            count_d   = count_q + CW'(1);
          end
        end
        dqmm_pkg::OP_PUSH_BACK: begin
          if (full) begin
            exec_res.status = dqmm_pkg::ST_FULL;
          end else begin
            back_d    = back_next;
            mem_we    = 1'b1;
            mem_waddr = back_q;
            count_d   = count_q + CW'(1);
          end
        end
        dqmm_pkg::OP_POP_FRONT: begin
          if (empty) begin
            exec_res.status = dqmm_pkg::ST_EMPTY;
          end else begin
            front_d = front_next;
            count_d = count_q - CW'(1);
          end
        end
        dqmm_pkg::OP_POP_BACK: begin
          if (empty) begin
            exec_res.status = dqmm_pkg::ST_EMPTY;
          end else begin
            back_d  = back_prev;
            count_d = count_q - CW'(1);
          end
        end
        dqmm_pkg::OP_QUERY: begin
          // only reaches here when empty
          exec_res.status = dqmm_pkg::ST_EMPTY;
        end
        default: begin
          exec_res.status = dqmm_pkg::ST_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      back_q  <= '0;
      count_q <= '0;
    end else begin
      front_q <= front_d;
      back_q  <= back_d;
      count_q <= count_d;
    end
  end

  // ring store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= in_item_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue_rd) begin
      rd_data_q <= mem[scan_ptr_q];
    end
  end

  // scan address walk
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_scan) begin
      scan_ptr_q  <= front_q;
      remaining_q <= count_q;
    end else if (cmd_i.issue_rd) begin
      scan_ptr_q  <= scan_next;
      remaining_q <= remaining_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.issue_rd;
    end
  end

  // running max / min
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_scan) begin
      first_q <= 1'b1;
    end else if (rd_vld_q) begin
      first_q <= 1'b0;
      if (first_q) begin
        hi_q <= $signed(rd_data_q);
        lo_q <= $signed(rd_data_q);
      end else begin
        if ($signed(rd_data_q) > hi_q) begin
          hi_q <= $signed(rd_data_q);
        end
        if ($signed(rd_data_q) < lo_q) begin
          lo_q <= $signed(rd_data_q);
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec || cmd_i.load_result) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      out_item_q <= exec_res;
    end else if (cmd_i.load_result) begin
      out_item_q.status    <= dqmm_pkg::ST_DONE;
      out_item_q.max_value <= hi_q;
      out_item_q.min_value <= lo_q;
    end
  end

  assign out_item_o  = out_item_q;
  assign out_valid_o = out_valid_q;

  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign sts_o.scan_req   = (in_item_i.opcode == dqmm_pkg::OP_QUERY) && !empty;
  assign sts_o.last_issue = (remaining_q == CW'(1));

endmodule
